// ===== rtl/core/gnf_pkg.sv =====
// Shared types, constants and hash function for the gradient noise fractal block.
package gnf_pkg;

    // Fixed field widths of the block's ports and item buses
    localparam int POS_W      = 32;
    localparam int OUT_W      = 24;
    localparam int FREQ_W     = 40;
    localparam int HALF_W     = 20;
    localparam int AMP_W      = 37;
    localparam int SUM_W      = 48;
    localparam int SEED_W     = 32;
    localparam int PERS_W     = 18;
    localparam int LAC_W      = 21;
    localparam int CNT_W      = 4;
    localparam int OCT_N_W    = 5;
    localparam int CELL_W     = 8;
    localparam int HSEL_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Default parameter values
    localparam int DEF_MAX_OCTAVES = 8;
    localparam int DEF_FRAC_BITS   = 16;

    // Register reset values
    localparam logic [SEED_W-1:0] RST_SEED    = SEED_W'(12345);
    localparam logic              RST_FRAC_EN = 1'b1;
    localparam logic [CNT_W-1:0]  RST_OCT_CNT = CNT_W'(4);
    localparam logic [PERS_W-1:0] RST_PERS    = PERS_W'(32768);
    localparam logic [LAC_W-1:0]  RST_LAC     = LAC_W'(131072);

    // Amplitude ceiling, 2^36
    localparam logic [AMP_W-1:0] AMP_CAP = AMP_W'(1) << 36;

    // Corner hash primes
    localparam logic [31:0] PRIME_X = 32'd73856093;
    localparam logic [31:0] PRIME_Y = 32'd19349663;
    localparam logic [31:0] PRIME_Z = 32'd83492791;

    // Quintic fade 6t^5 - 15t^4 + 10t^3
    localparam int FADE_A = 6;
    localparam int FADE_B = 15;
    localparam int FADE_C = 10;

    // Gradient select codes
    localparam logic [HSEL_W-1:0] GRAD_U_Y_FROM = 4'd8;
    localparam logic [HSEL_W-1:0] GRAD_V_Z_FROM = 4'd4;
    localparam logic [HSEL_W-1:0] GRAD_V_X_A    = 4'd12;
    localparam logic [HSEL_W-1:0] GRAD_V_X_B    = 4'd14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED    = 3'd0,
        REG_FRAC_EN = 3'd1,
        REG_OCT_CNT = 3'd2,
        REG_PERS    = 3'd3,
        REG_LAC     = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [SEED_W-1:0]  seed;
        logic [PERS_W-1:0]  pers;
        logic [LAC_W-1:0]   lac;
        logic [OCT_N_W-1:0] oct_n;
    } t_cfg;

    typedef struct packed {
        logic                    valid;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [FREQ_W-1:0]       freq;
        logic [AMP_W-1:0]        amp;
        logic signed [SUM_W-1:0] sum;
    } t_oct_bus;

    // Low hash bits that pick the gradient of one lattice corner
    function automatic logic [HSEL_W-1:0] hash_sel(input logic [CELL_W-1:0] cx,
                                                   input logic [CELL_W-1:0] cy,
                                                   input logic [CELL_W-1:0] cz,
                                                   input logic [SEED_W-1:0] seed);
        logic [31:0] h;
        h = ({24'b0, cx} * PRIME_X) ^ ({24'b0, cy} * PRIME_Y)
          ^ ({24'b0, cz} * PRIME_Z) ^ seed;
        return h[HSEL_W-1:0];
    endfunction

endpackage

// ===== rtl/core/gnf_octave.sv =====
// One pipelined noise octave: scale, hash, fade, trilinear blend, weighted accumulate.
module gnf_octave
    import gnf_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int OCT_IDX   = 0
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_cfg     i_cfg,
    input  t_oct_bus i_bus,
    output t_oct_bus o_bus
);

    localparam int F     = FRAC_BITS;
    localparam int PW    = F + CELL_W;
    localparam int TW    = F + 1;
    localparam int DW    = F + 2;
    localparam int GW    = F + 4;
    localparam int IW    = F + 4;
    localparam int MW    = F + 7;
    localparam int M1W   = 2 * F + 7;
    localparam int LPW   = TW + GW + 2;
    localparam int GPW   = GW + AMP_W + 1;
    localparam int PPW   = POS_W + HALF_W + 1;
    localparam int PSW   = PPW + HALF_W;
    localparam int FQW   = HALF_W + LAC_W;
    localparam int APW   = AMP_W + PERS_W;
    localparam int NST   = 12;

    localparam logic signed [DW-1:0] ONE_D  = DW'(1 << F);
    localparam logic [F+5:0]         C15    = (F + 6)'(FADE_B) << F;
    localparam logic signed [MW-1:0] C10    = MW'(FADE_C) << F;

    typedef struct packed {
        logic                    act;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [FREQ_W-1:0]       freq;
        logic [AMP_W-1:0]        amp;
        logic [AMP_W-1:0]        amp_nx;
        logic signed [SUM_W-1:0] sum;
    } t_carry;

    function automatic logic signed [GW-1:0] grad_sum(input logic [HSEL_W-1:0] h,
                                                      input logic signed [DW-1:0] gx,
                                                      input logic signed [DW-1:0] gy,
                                                      input logic signed [DW-1:0] gz);
        logic signed [GW-1:0] gu;
        logic signed [GW-1:0] gv;
        logic signed [GW-1:0] ex;
        logic signed [GW-1:0] ey;
        logic signed [GW-1:0] ez;
        ex = {{2{gx[DW-1]}}, gx};
        ey = {{2{gy[DW-1]}}, gy};
        ez = {{2{gz[DW-1]}}, gz};
        gu = (h < GRAD_U_Y_FROM) ? ex : ey;
        if (h < GRAD_V_Z_FROM) begin
            gv = ey;
        end else if (h == GRAD_V_X_A || h == GRAD_V_X_B) begin
            gv = ex;
        end else begin
            gv = ez;
        end
        return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
    endfunction

    function automatic logic signed [LPW-1:0] lerp_mul(input logic [TW-1:0] t,
                                                       input logic signed [GW-1:0] a,
                                                       input logic signed [GW-1:0] b);
        logic signed [GW:0] diff;
        diff = {b[GW-1], b} - {a[GW-1], a};
        return $signed({1'b0, t}) * diff;
    endfunction

    function automatic logic signed [GW-1:0] lerp_add(input logic signed [GW-1:0] a,
                                                      input logic signed [LPW-1:0] p);
        logic signed [GW:0] s;
        s = {a[GW-1], a} + $signed(p[F +: GW + 1]);
        return s[GW-1:0];
    endfunction

    logic                    r_vld [1:NST];
    t_carry                  r_cy  [1:NST];
    t_carry                  w2_cy;

    logic signed [POS_W-1:0] w_pos   [3];
    logic signed [PPW-1:0]   w1_plo  [3];
    logic signed [PPW-1:0]   w1_phi  [3];
    logic [FQW-1:0]          w1_fqlo;
    logic [FQW-1:0]          w1_fqhi;
    logic [APW-1:0]          w1_ap;

    logic signed [PPW-1:0]   r1_plo  [3];
    logic signed [PPW-1:0]   r1_phi  [3];
    logic [FQW-1:0]          r1_fqlo;
    logic [FQW-1:0]          r1_fqhi;
    logic [APW-1:0]          r1_ap;

    logic signed [PSW-1:0]   w2_wide [3];
    logic [63:0]             w2_fq;
    logic [APW-1:0]          w2_ap;
    logic [FREQ_W-1:0]       w2_freq;
    logic [AMP_W-1:0]        w2_amp;
    logic [PW-1:0]           r2_s    [3];

    logic [F-1:0]            w3_f    [3];
    logic [2*F-1:0]          w3_sq   [3];
    logic [F+5:0]            w3_f6   [3];
    logic signed [F+5:0]     w3_d    [3];
    logic signed [M1W-1:0]   w3_m1   [3];
    logic [CELL_W-1:0]       w3_ci   [3];
    logic [CELL_W-1:0]       w3_ci1  [3];
    logic signed [DW-1:0]    w3_dlo  [3];
    logic signed [DW-1:0]    w3_dhi  [3];
    logic [HSEL_W-1:0]       w3_h    [8];
    logic signed [GW-1:0]    w3_g    [8];
    logic [F-1:0]            r3_f    [3];
    logic [F-1:0]            r3_tt   [3];
    logic signed [MW-1:0]    r3_m1   [3];
    logic signed [GW-1:0]    r3_g    [8];

    logic [2*F-1:0]          w4_cu   [3];
    logic signed [MW-1:0]    w4_in   [3];
    logic [F-1:0]            r4_t3   [3];
    logic [IW-1:0]           r4_in   [3];
    logic signed [GW-1:0]    r4_g    [8];

    logic [F+IW-1:0]         w5_fp   [3];
    logic [TW-1:0]           r5_fd   [3];
    logic signed [GW-1:0]    r5_g    [8];

    logic signed [LPW-1:0]   r6_p    [4];
    logic signed [GW-1:0]    r6_a    [4];
    logic [TW-1:0]           r6_v;
    logic [TW-1:0]           r6_w;
    logic signed [GW-1:0]    r7_l    [4];
    logic [TW-1:0]           r7_v;
    logic [TW-1:0]           r7_w;
    logic signed [LPW-1:0]   r8_p    [2];
    logic signed [GW-1:0]    r8_a    [2];
    logic [TW-1:0]           r8_w;
    logic signed [GW-1:0]    r9_l    [2];
    logic [TW-1:0]           r9_w;
    logic signed [LPW-1:0]   r10_p;
    logic signed [GW-1:0]    r10_a;
    logic signed [GW-1:0]    r11_g;
    logic signed [GPW-1:0]   r12_gp;
    logic signed [GPW-1:0]   w13_sh;

    // Stage 1: partial products of position x frequency, frequency and amplitude updates
    always_comb begin
        w_pos[0] = i_bus.pos_x;
        w_pos[1] = i_bus.pos_y;
        w_pos[2] = i_bus.pos_z;
        for (int a = 0; a < 3; a++) begin
            w1_plo[a] = w_pos[a] * $signed({1'b0, i_bus.freq[HALF_W-1:0]});
            w1_phi[a] = w_pos[a] * $signed({1'b0, i_bus.freq[FREQ_W-1:HALF_W]});
        end
        w1_fqlo = i_bus.freq[HALF_W-1:0] * i_cfg.lac;
        w1_fqhi = i_bus.freq[FREQ_W-1:HALF_W] * i_cfg.lac;
        w1_ap   = i_bus.amp * i_cfg.pers;
    end

    // Stage 2: merge partials; keep the lattice cell mod 256 with its fraction
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w2_wide[a] = {{HALF_W{r1_plo[a][PPW-1]}}, r1_plo[a]}
                       + ({{HALF_W{r1_phi[a][PPW-1]}}, r1_phi[a]} <<< HALF_W);
        end
        w2_fq   = 64'(r1_fqlo) + (64'(r1_fqhi) << HALF_W);
        w2_freq = w2_fq[F +: FREQ_W];
        w2_ap   = r1_ap >> F;
        w2_amp  = (w2_ap > APW'(AMP_CAP)) ? AMP_CAP : w2_ap[AMP_W-1:0];
        w2_cy        = r_cy[1];
        w2_cy.freq   = w2_freq;
        w2_cy.amp_nx = w2_amp;
    end

    // Stage 3: first fade step, corner hashes and gradient sums
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w3_f[a]   = r2_s[a][F-1:0];
            w3_ci[a]  = r2_s[a][PW-1:F];
            w3_ci1[a] = w3_ci[a] + CELL_W'(1);
            w3_sq[a]  = w3_f[a] * w3_f[a];
            w3_f6[a]  = {6'b0, w3_f[a]} * (F + 6)'(FADE_A);
            w3_d[a]   = $signed(w3_f6[a]) - $signed(C15);
            w3_m1[a]  = $signed({1'b0, w3_f[a]}) * w3_d[a];
            w3_dlo[a] = $signed({2'b0, w3_f[a]});
            w3_dhi[a] = w3_dlo[a] - ONE_D;
        end
        for (int c = 0; c < 8; c++) begin
            w3_h[c] = hash_sel(((c & 1) != 0) ? w3_ci1[0] : w3_ci[0],
                               ((c & 2) != 0) ? w3_ci1[1] : w3_ci[1],
                               ((c & 4) != 0) ? w3_ci1[2] : w3_ci[2],
                               i_cfg.seed);
            w3_g[c] = grad_sum(w3_h[c],
                               ((c & 1) != 0) ? w3_dhi[0] : w3_dlo[0],
                               ((c & 2) != 0) ? w3_dhi[1] : w3_dlo[1],
                               ((c & 4) != 0) ? w3_dhi[2] : w3_dlo[2]);
        end
    end

    // Stages 4 and 5: finish the quintic fade
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w4_cu[a] = r3_tt[a] * r3_f[a];
            w4_in[a] = r3_m1[a] + C10;
            w5_fp[a] = r4_t3[a] * r4_in[a];
        end
    end

    assign w13_sh = r12_gp >>> F;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NST; k++) begin
                r_vld[k] <= 1'b0;
            end
            o_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_vld[1] <= i_bus.valid;
            for (int k = 2; k <= NST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            o_bus.valid <= r_vld[NST];
            o_bus.pos_x <= r_cy[NST].pos_x;
            o_bus.pos_y <= r_cy[NST].pos_y;
            o_bus.pos_z <= r_cy[NST].pos_z;
            o_bus.freq  <= r_cy[NST].freq;
            o_bus.amp   <= r_cy[NST].amp_nx;
            o_bus.sum   <= r_cy[NST].act ? r_cy[NST].sum + w13_sh[SUM_W-1:0]
                                         : r_cy[NST].sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // carried item fields
            r_cy[1].act    <= (OCT_N_W'(OCT_IDX) < i_cfg.oct_n);
            r_cy[1].pos_x  <= i_bus.pos_x;
            r_cy[1].pos_y  <= i_bus.pos_y;
            r_cy[1].pos_z  <= i_bus.pos_z;
            r_cy[1].freq   <= i_bus.freq;
            r_cy[1].amp    <= i_bus.amp;
            r_cy[1].amp_nx <= i_bus.amp;
            r_cy[1].sum    <= i_bus.sum;
            r_cy[2]        <= w2_cy;
            for (int k = 3; k <= NST; k++) begin
                r_cy[k] <= r_cy[k-1];
            end

            r1_plo  <= w1_plo;
            r1_phi  <= w1_phi;
            r1_fqlo <= w1_fqlo;
            r1_fqhi <= w1_fqhi;
            r1_ap   <= w1_ap;

            for (int a = 0; a < 3; a++) begin
                r2_s[a]  <= w2_wide[a][F +: PW];
                r3_f[a]  <= w3_f[a];
                r3_tt[a] <= w3_sq[a][2*F-1:F];
                r3_m1[a] <= $signed(w3_m1[a][F +: MW]);
                r4_t3[a] <= w4_cu[a][2*F-1:F];
                r4_in[a] <= w4_in[a][IW-1:0];
                r5_fd[a] <= w5_fp[a][F +: TW];
            end
            r3_g <= w3_g;
            r4_g <= r3_g;
            r5_g <= r4_g;

            // blend along x
            for (int i = 0; i < 4; i++) begin
                r6_p[i] <= lerp_mul(r5_fd[0], r5_g[2*i], r5_g[2*i+1]);
                r6_a[i] <= r5_g[2*i];
                r7_l[i] <= lerp_add(r6_a[i], r6_p[i]);
            end
            r6_v <= r5_fd[1];
            r6_w <= r5_fd[2];
            r7_v <= r6_v;
            r7_w <= r6_w;

            // blend along y
            for (int i = 0; i < 2; i++) begin
                r8_p[i] <= lerp_mul(r7_v, r7_l[2*i], r7_l[2*i+1]);
                r8_a[i] <= r7_l[2*i];
                r9_l[i] <= lerp_add(r8_a[i], r8_p[i]);
            end
            r8_w <= r7_w;
            r9_w <= r8_w;

            // blend along z, weight by amplitude
            r10_p  <= lerp_mul(r9_w, r9_l[0], r9_l[1]);
            r10_a  <= r9_l[0];
            r11_g  <= lerp_add(r10_a, r10_p);
            r12_gp <= r11_g * $signed({1'b0, r_cy[11].amp});
        end
    end

endmodule

// ===== rtl/core/gradient_noise_fractal_3d.sv =====
// Top level of the 3D gradient noise block with fractal octave sum.
// Each item is one sample position (x, y, z, signed fixed point with FRAC_BITS fraction
// bits); each result is one saturated 24-bit noise value, in the order the items came.
// The octaves are unrolled: MAX_OCTAVES copies of a 13-stage octave pipeline follow an
// input register, then a saturation stage and a two-entry output buffer. One item is
// taken every cycle unless the output buffer is full; a result passes the input register,
// the octave chain and the saturation register into the buffer. Inputs keep flowing while
// a result waits; the pipe holds only once two results are waiting.
// Octaves past the active count pass the sum unchanged. Configuration is a plain write
// port (seed, fractal enable, octave count, persistence, lacunarity); write it only while
// no item is in flight.
module gradient_noise_fractal_3d
    import gnf_pkg::*;
#(
    parameter int MAX_OCTAVES = DEF_MAX_OCTAVES,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [OUT_W-1:0] o_noise_value,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SKID_DEPTH = 2;
    localparam int CNT_BITS   = $clog2(SKID_DEPTH + 1);

    // Configuration registers
    logic [SEED_W-1:0]  r_seed;
    logic               r_frac_en;
    logic [CNT_W-1:0]   r_oct_cnt;
    logic [PERS_W-1:0]  r_pers;
    logic [LAC_W-1:0]   r_lac;
    logic [OCT_N_W-1:0] w_oct_n;
    t_cfg               w_cfg;

    logic               w_en;
    t_oct_bus           r_in;
    t_oct_bus           w_bus [0:MAX_OCTAVES];

    logic                    r_sat_vld;
    logic signed [OUT_W-1:0] r_sat_val;
    logic signed [OUT_W-1:0] w_sat;
    logic signed [SUM_W-1:0] w_sum;

    logic signed [OUT_W-1:0] r_q [SKID_DEPTH];
    logic [CNT_BITS-1:0]     r_cnt;
    logic [CNT_BITS-1:0]     w_wr;
    logic                    w_push;
    logic                    w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed    <= RST_SEED;
            r_frac_en <= RST_FRAC_EN;
            r_oct_cnt <= RST_OCT_CNT;
            r_pers    <= RST_PERS;
            r_lac     <= RST_LAC;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SEED:    r_seed    <= i_cfg_data[SEED_W-1:0];
                REG_FRAC_EN: r_frac_en <= i_cfg_data[0];
                REG_OCT_CNT: r_oct_cnt <= i_cfg_data[CNT_W-1:0];
                REG_PERS:    r_pers    <= i_cfg_data[PERS_W-1:0];
                REG_LAC:     r_lac     <= i_cfg_data[LAC_W-1:0];
                default:     ;
            endcase
        end
    end

    // Active octave count: one when fractal mode is off or the count is zero,
    // clamped to the number of octave stages built.
    always_comb begin
        w_oct_n = OCT_N_W'(1);
        if (r_frac_en && r_oct_cnt != '0) begin
            if (OCT_N_W'(r_oct_cnt) > OCT_N_W'(MAX_OCTAVES)) begin
                w_oct_n = OCT_N_W'(MAX_OCTAVES);
            end else begin
                w_oct_n = OCT_N_W'(r_oct_cnt);
            end
        end
        w_cfg.seed  = r_seed;
        w_cfg.pers  = r_pers;
        w_cfg.lac   = r_lac;
        w_cfg.oct_n = w_oct_n;
    end

    // The whole pipe advances together; hold it only while the output buffer is full.
    assign w_en       = (r_cnt != CNT_BITS'(SKID_DEPTH));
    assign o_in_ready = w_en;

    // Input register: frequency and amplitude start at one, sum at zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_en) begin
            r_in.valid <= i_in_valid;
            r_in.pos_x <= i_pos_x;
            r_in.pos_y <= i_pos_y;
            r_in.pos_z <= i_pos_z;
            r_in.freq  <= FREQ_W'(1) << FRAC_BITS;
            r_in.amp   <= AMP_W'(1) << FRAC_BITS;
            r_in.sum   <= '0;
        end
    end

    assign w_bus[0] = r_in;

    for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
        gnf_octave #(
            .FRAC_BITS (FRAC_BITS),
            .OCT_IDX   (k)
        ) u_oct (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cfg   (w_cfg),
            .i_bus   (w_bus[k]),
            .o_bus   (w_bus[k+1])
        );
    end

    // Saturate the octave sum to the output width
    always_comb begin
        w_sum = w_bus[MAX_OCTAVES].sum;
        if (!w_sum[SUM_W-1] && (|w_sum[SUM_W-2:OUT_W-1])) begin
            w_sat = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (w_sum[SUM_W-1] && !(&w_sum[SUM_W-2:OUT_W-1])) begin
            w_sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            w_sat = w_sum[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_vld <= 1'b0;
        end else if (w_en) begin
            r_sat_vld <= w_bus[MAX_OCTAVES].valid;
            r_sat_val <= w_sat;
        end
    end

    // Output buffer: drop the head on a take, append a finished item behind it
    assign w_push = w_en && r_sat_vld;
    assign w_pop  = o_out_valid && i_out_ready;
    assign w_wr   = r_cnt - CNT_BITS'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CNT_BITS'(w_push) - CNT_BITS'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && w_wr == CNT_BITS'(0)) begin
            r_q[0] <= r_sat_val;
        end else if (w_pop) begin
            r_q[0] <= r_q[1];
        end
        if (w_push && w_wr == CNT_BITS'(1)) begin
            r_q[1] <= r_sat_val;
        end
    end

    assign o_out_valid   = (r_cnt != '0);
    assign o_noise_value = r_q[0];

endmodule

// ===== rtl/core/gnf_checker.sv =====
// Port-level checks for the gradient noise block, bound to the top level.
module gnf_checker
    import gnf_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic signed [OUT_W-1:0] o_noise_value
);

    logic [15:0] r_pending;

    // Items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 16'(i_in_valid && o_in_ready)
                                   - 16'(o_out_valid && i_out_ready);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_noise_value))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 16'd0)
        else $error("result without an accepted item");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input held with no result waiting");

endmodule

bind gradient_noise_fractal_3d gnf_checker u_gnf_checker (.*);
